@@ src/mdxs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdxs_pkg
// Field widths, register map and bus widths shared by the disjoint XOR
// segment counter.
// ----------------------------------------------------------------------------
package mdxs_pkg;

  // Widths of the stream fields.
  localparam int unsigned ValueW     = 16;
  localparam int unsigned BestCountW = 24;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 24;

  // Configuration port.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned TargetW  = 16;

  // Register index, taken from the word address bit of paddr.
  localparam logic RegTargetXor = 1'b0;

endpackage

@@ src/max_disjoint_xor_segments.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_disjoint_xor_segments
// Streaming count of the largest number of disjoint contiguous segments whose
// XOR equals a programmable target.
// ----------------------------------------------------------------------------
// Each input beat carries one value of the sequence, and each accepted beat
// produces exactly one output beat: the largest number of non-overlapping
// segments, within the sequence so far, whose XOR equals target_xor. The
// block takes one beat per clock cycle in steady state while the output
// queue has room; a result passes through the write-back stage into the
// output queue. The rate is set by the read-modify-write of the prefix table:
// the table is read when a beat is accepted and written back in the following
// cycle, and a read that collides with the write of the item just ahead of it
// is served from a forwarding register. After reset the block runs a clearing
// pass over the prefix table, one entry per cycle, over all 2**VALUE_BITS
// entries; s_axis_tready stays low until it has finished, although
// configuration writes are taken throughout. A new sequence needs a reset.
// Write target_xor only while the block is idle.
// ----------------------------------------------------------------------------
module max_disjoint_xor_segments #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mdxs_pkg::InTdataW-1:0]  s_axis_tdata,   // [15:0] value
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mdxs_pkg::OutTdataW-1:0] m_axis_tdata,   // [23:0] best_count
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mdxs_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mdxs_pkg::ApbDataW-1:0]  pwdata,
  output logic [mdxs_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import mdxs_pkg::*;

  // The table holds one entry for every prefix value. Each entry is a valid
  // flag above the best count that was reached at the latest position with
  // that prefix.
  localparam int unsigned TableDepth = 2 ** VALUE_BITS;
  localparam int unsigned EntryW     = COUNT_BITS + 1;
  localparam int unsigned VextW      = (VALUE_BITS > ValueW) ? VALUE_BITS : ValueW;
  localparam int unsigned TextW      = (VALUE_BITS > TargetW) ? VALUE_BITS : TargetW;
  localparam int unsigned CextW      = (COUNT_BITS > BestCountW) ? COUNT_BITS : BestCountW;
  localparam int unsigned OutDepth   = 3;
  localparam int unsigned PtrW       = $clog2(OutDepth);
  localparam int unsigned OccW       = $clog2(OutDepth + 1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [TargetW-1:0] target_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegTargetXor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_wr) begin
      target_q <= pwdata[TargetW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegTargetXor) begin
      prdata = {{(ApbDataW - TargetW){1'b0}}, target_q};
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass over the table after reset
  // --------------------------------------------------------------------------
  logic                  clr_busy_q;
  logic [VALUE_BITS-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + VALUE_BITS'(1);
      if (clr_idx_q == {VALUE_BITS{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage: prefix update and table read
  // --------------------------------------------------------------------------
  logic                  s1_valid_q;
  logic [OccW-1:0]       occ_q;
  logic                  s_accept;
  logic [VextW-1:0]      in_ext;
  logic [TextW-1:0]      tgt_ext;
  logic [VALUE_BITS-1:0] in_value;
  logic [VALUE_BITS-1:0] tgt_value;
  logic [VALUE_BITS-1:0] prefix_q;
  logic [VALUE_BITS-1:0] prefix_d;
  logic [VALUE_BITS-1:0] look_addr;

  // Room is counted for the item in the write-back stage as well as the
  // results already queued, so a result never finds the queue full.
  assign s_axis_tready = !clr_busy_q &&
                         ((OccW + 1)'(occ_q) + (OccW + 1)'(s1_valid_q) <
                          (OccW + 1)'(OutDepth));
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_ext    = VextW'(s_axis_tdata);
  assign tgt_ext   = TextW'(target_q);
  assign in_value  = in_ext[VALUE_BITS-1:0];
  assign tgt_value = tgt_ext[VALUE_BITS-1:0];
  assign prefix_d  = prefix_q ^ in_value;
  assign look_addr = prefix_d ^ tgt_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s_accept;
      if (s_accept) begin
        prefix_q <= prefix_d;
      end
    end
  end

  logic [VALUE_BITS-1:0] s1_prefix_q;
  logic [VALUE_BITS-1:0] s1_look_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_prefix_q <= prefix_d;
      s1_look_q   <= look_addr;
    end
  end

  // --------------------------------------------------------------------------
  // Prefix table: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [EntryW-1:0]     tbl_mem [TableDepth];
  logic [EntryW-1:0]     rd_data_q;
  logic                  tbl_we;
  logic [VALUE_BITS-1:0] tbl_waddr;
  logic [EntryW-1:0]     tbl_wdata;
  logic [COUNT_BITS-1:0] best_d;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = s1_prefix_q;
    tbl_wdata = {1'b1, best_d};
    if (clr_busy_q) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_idx_q;
      tbl_wdata = '0;
    end else if (s1_valid_q) begin
      tbl_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rd_data_q <= tbl_mem[look_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Write-back stage: candidate, running best, forwarding
  // --------------------------------------------------------------------------
  // A read issued at the same edge as the previous item's write-back misses
  // that write, so the written entry is kept in a forwarding register and used
  // instead when the addresses match.
  logic                  fwd_valid_q;
  logic [VALUE_BITS-1:0] fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [COUNT_BITS-1:0] best_q;
  logic                  fwd_hit;
  logic [EntryW-1:0]     entry;
  logic [COUNT_BITS-1:0] entry_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cand;

  assign fwd_hit   = fwd_valid_q && (fwd_addr_q == s1_look_q);
  assign entry     = fwd_hit ? {1'b1, fwd_data_q} : rd_data_q;
  assign entry_cnt = entry[COUNT_BITS-1:0];
  // The count saturates at all ones.
  assign cnt_inc   = (entry_cnt == {COUNT_BITS{1'b1}}) ? entry_cnt
                                                       : entry_cnt + COUNT_BITS'(1);

  always_comb begin
    if (entry[COUNT_BITS]) begin
      cand = cnt_inc;
    end else if (s1_look_q == '0) begin
      // The whole prefix so far is itself a matching segment.
      cand = COUNT_BITS'(1);
    end else begin
      cand = '0;
    end
    best_d = best_q;
    if (s1_valid_q && (cand > best_q)) begin
      best_d = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      best_q      <= best_d;
      fwd_valid_q <= s1_valid_q && s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_prefix_q;
    fwd_data_q <= best_d;
  end

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  logic [CextW-1:0]      best_ext;
  logic [BestCountW-1:0] out_q [OutDepth];
  logic [PtrW-1:0]       wr_ptr_q;
  logic [PtrW-1:0]       rd_ptr_q;
  logic                  push;
  logic                  pop;

  assign best_ext      = CextW'(best_d);
  assign push          = s1_valid_q;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (occ_q != '0);
  assign m_axis_tdata  = OutTdataW'(out_q[rd_ptr_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        occ_q <= occ_q + OccW'(1);
      end else if (pop && !push) begin
        occ_q <= occ_q - OccW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q[wr_ptr_q] <= best_ext[BestCountW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // No item may enter while the table is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("input accepted during the clearing pass");

  // Queued results and the item in write-back never exceed the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((OccW + 1)'(occ_q) + (OccW + 1)'(s1_valid_q)) <= (OccW + 1)'(OutDepth))
    else $error("output queue overrun");

  // The running best never decreases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (best_q >= $past(best_q)))
    else $error("running best decreased");

  // Forwarded data only ever serves an item that is in write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> s1_valid_q)
    else $error("forwarding armed without an item in write-back");

  // No result is lost in the queue: a pushed result is visible on the next
  // cycle when the queue was empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (occ_q == '0)) |=> m_axis_tvalid)
    else $error("result lost in the output queue");

endmodule

@@ test/segment_count_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_count_checker
// Watches the streams and the configuration port of the disjoint XOR segment
// counter, predicts every output beat and compares it with what arrives.
// ----------------------------------------------------------------------------
module segment_count_checker
  import mdxs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [InTdataW-1:0]  in_data_i,    // [15:0] value
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [OutTdataW-1:0] out_data_i,   // [23:0] best_count
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [ApbAddrW-1:0]  paddr_i,
  input  logic [ApbDataW-1:0]  pwdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int unsigned TableDepth = 1 << ValueW;

  typedef logic [BestCountW-1:0] count_t;
  typedef logic [ValueW-1:0]     value_t;

  localparam count_t CountMax = '1;

  value_t target_q;
  value_t prefix_q;
  count_t best_q;
  bit     seen_q [TableDepth];
  count_t best_at_q [TableDepth];
  count_t expected_counts [$];
  int     mismatches = 0;

  // Folds one value into the prefix and returns the new best count. The
  // entry for the looked-up prefix is read before the current prefix is
  // written, so a target of zero sees the previous visit of the same prefix.
  function automatic count_t advance_prefix(input value_t v);
    value_t look;
    count_t cand;
    prefix_q = prefix_q ^ v;
    look     = prefix_q ^ target_q;
    if (seen_q[look]) begin
      cand = (best_at_q[look] == CountMax) ? CountMax : best_at_q[look] + 1'b1;
    end else begin
      cand = (look == '0) ? count_t'(1) : count_t'(0);
    end
    if (cand > best_q) begin
      best_q = cand;
    end
    seen_q[prefix_q]    = 1'b1;
    best_at_q[prefix_q] = best_q;
    return best_q;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    count_t got;
    count_t want;
    if (!rst_ni) begin
      target_q = '0;
      prefix_q = '0;
      best_q   = '0;
      for (int i = 0; i < TableDepth; i++) begin
        seen_q[i] = 1'b0;
      end
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[BestCountW-1:0];
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("output beat with no input behind it: best_count %0d",
                                    got));
        end else begin
          want = expected_counts.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf("best_count is %0d, predicted %0d", got, want));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_counts.push_back(advance_prefix(in_data_i[ValueW-1:0]));
      end
      // Only the word address bit selects a register; the second word is
      // unmapped and a write there leaves the target alone.
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == RegTargetXor) begin
        target_q = pwdata_i[ValueW-1:0];
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_counts.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the disjoint XOR segment counter.
// ----------------------------------------------------------------------------
// After a single reset the block clears its prefix table, then takes a short
// directed sequence at the reset target and at the all-ones target, followed
// by several random phases, each with its own target and its own pattern of
// idle cycles on the input and stalls on the output. Most random values are
// chosen so that matching segments are common and the counts climb: single
// beats equal to the target, and beats that close a segment opened a few
// beats earlier. The checker beside the block predicts and compares every
// output beat; this module only drives the ports and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import mdxs_pkg::*;

  typedef logic [ValueW-1:0] value_t;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idling_e;

  localparam int unsigned ClkPeriod  = 4;
  localparam int unsigned StallLimit = 300_000;  // well above the clearing pass
  localparam int unsigned HoldCycles = 400;

  // Byte addresses on the configuration port.
  localparam logic [ApbAddrW-1:0] TargetXorAddr = 3'd0;
  localparam logic [ApbAddrW-1:0] UnmappedAddr  = 3'd4;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;   // [15:0] value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;          // [23:0] best_count
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ApbAddrW-1:0]  paddr         = '0;
  logic [ApbDataW-1:0]  pwdata        = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  int fail_count;
  int pending;

  // Sender side bookkeeping: the prefix of everything sent so far and a
  // short history of earlier prefixes, used to aim segments at the target.
  value_t      target_now = '0;
  value_t      stream_prefix = '0;
  value_t      recent_prefixes [8] = '{default: '0};
  int unsigned recent_idx = 0;
  int unsigned send_idle_pct = 0;

  // Receiver side: stall rate, and long hold-offs requested by the stimulus
  // and counted out in the receiver's own process.
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;

  int unsigned quiet_cycles = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  max_disjoint_xor_segments dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  segment_count_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver. A requested hold-off keeps tready low for a long stretch so
  // that the pipeline fills and the input side has to stall; otherwise
  // tready is drawn afresh every cycle at the current stall rate.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      m_axis_tready <= 1'b0;
      hold_served   <= hold_served + 1;
      hold_left     <= HoldCycles;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any handshake on either stream or on the configuration port
  // counts as progress. The limit is well above the clearing pass.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one value, with random idle cycles in front of it, and returns
  // just after the clock edge at which it was accepted. tvalid stays high
  // into the next call unless that call begins with an idle cycle.
  task automatic send_value(input value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    stream_prefix               = stream_prefix ^ v;
    recent_prefixes[recent_idx] = stream_prefix;
    recent_idx                  = (recent_idx + 1) % 8;
  endtask

  // Setup cycle then access cycle; the write lands at the access edge. The bus
  // then goes idle, so a second write starts afresh with its own setup.
  task automatic write_reg(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering, waits until every predicted beat has come out, then
  // lets the last table write-back finish. The first edge lets the checker
  // register the beat accepted just before.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Programs the target with random junk above the used bits, which the
  // block must ignore.
  task automatic set_target(input value_t tgt);
    write_reg(TargetXorAddr, {16'($urandom_range(16'hFFFF)), tgt});
    target_now = tgt;
  endtask

  task automatic set_idling(input idling_e mode);
    send_idle_pct   = (mode == IdleSender) ? 77 : (mode == IdleBoth) ? 32 : 0;
    recv_stall_pct <= (mode == IdleReceiver) ? 77 : (mode == IdleBoth) ? 32 : 0;
  endtask

  // Mostly values that complete a segment equal to the target, either alone
  // or together with the beats since an earlier prefix; the rest are small
  // values that make prefixes repeat, and full-range noise.
  function automatic value_t pick_value();
    int unsigned roll = $urandom_range(99);
    if (roll < 30) begin
      return target_now;
    end
    if (roll < 55) begin
      return stream_prefix ^ target_now ^ recent_prefixes[$urandom_range(7)];
    end
    if (roll < 80) begin
      return value_t'($urandom_range(7));
    end
    return value_t'($urandom_range(16'hFFFF));
  endfunction

  // One random phase. hold_at and pause_at give the beat at which a long
  // receiver hold-off starts or the sender waits for the output to drain;
  // a negative index means none. With shuffle set the idling pattern is
  // redrawn every 25 beats after the first 25.
  task automatic run_phase(input value_t tgt, input idling_e mode, input int n_items,
                           input int hold_at, input int pause_at, input bit shuffle);
    settle();
    set_target(tgt);
    set_idling(mode);
    for (int i = 0; i < n_items; i++) begin
      if (shuffle && i > 0 && i % 25 == 0) begin
        set_idling(idling_e'($urandom_range(3)));
      end
      if (i == hold_at) begin
        hold_requests <= hold_requests + 1;
      end
      if (i == pause_at) begin
        settle();
      end
      send_value(pick_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset target of zero: the first zero beat is a
    // matching segment on its own, the all-ones pair brings the prefix back
    // to zero, and the alternating patterns toggle every value bit. The
    // first beat waits out the clearing pass.
    send_value(16'h0000);
    send_value(16'hFFFF);
    send_value(16'hFFFF);
    send_value(16'h0001);
    send_value(16'h0001);
    send_value(16'h8000);
    send_value(16'h7FFF);
    send_value(16'h5555);
    send_value(16'hAAAA);

    // All-ones target, and a write to the unmapped word, which must not
    // disturb it. The prefix and the table carry over.
    settle();
    set_target(16'hFFFF);
    write_reg(UnmappedAddr, 32'h0000_0005);
    send_value(16'hFFFF);
    send_value(16'h0000);
    send_value(16'hFFFF);
    send_value(16'hFFFF);
    send_value(16'h1234);
    send_value(16'hEDCB);
    send_value(16'h0001);
    send_value(16'hFFFE);

    // Random phases. The first runs without idling and holds the receiver
    // off for a long stretch; the third has the sender drain the block
    // half way through.
    run_phase(value_t'($urandom_range(1, 15)), IdleNone, 150, 60, -1, 1'b0);
    run_phase(16'h0000, IdleSender, 150, -1, -1, 1'b0);
    run_phase(16'hFFFF, IdleReceiver, 150, -1, 75, 1'b0);
    run_phase(value_t'($urandom_range(16'hFFFF)), IdleBoth, 150, -1, -1, 1'b0);
    run_phase(16'h0001, IdleNone, 200, -1, -1, 1'b1);

    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
